FILE: hw/rtl/tslf_pkg.sv
package tslf_pkg;

  // Default sizes of the image and of the request fields.
  localparam int unsigned DefMaxRows   = 256;
  localparam int unsigned DefMaxCols   = 256;
  localparam int unsigned DefLabelBits = 16;
  localparam int unsigned DefCoordBits = 11;

  // Fixed field widths.
  localparam int unsigned OpcodeW     = 2;
  localparam int unsigned ReadCoordW  = 8;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 9;

  // Request operations.
  localparam logic [OpcodeW-1:0] OpDraw   = 2'd0;
  localparam logic [OpcodeW-1:0] OpRead   = 2'd1;
  localparam logic [OpcodeW-1:0] OpClear  = 2'd2;
  localparam logic [OpcodeW-1:0] OpUnused = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegImageRows = 1'b0;
  localparam logic [CfgIdxW-1:0] RegImageCols = 1'b1;

endpackage

FILE: hw/rtl/tslf_if.sv
interface tslf_req_if #(
  parameter int unsigned COORD_BITS = tslf_pkg::DefCoordBits,
  parameter int unsigned LABEL_BITS = tslf_pkg::DefLabelBits
);
  import tslf_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [OpcodeW-1:0]           opcode;
  logic signed [COORD_BITS-1:0] vertex_a_x;
  logic signed [COORD_BITS-1:0] vertex_a_y;
  logic signed [COORD_BITS-1:0] vertex_b_x;
  logic signed [COORD_BITS-1:0] vertex_b_y;
  logic signed [COORD_BITS-1:0] vertex_c_x;
  logic signed [COORD_BITS-1:0] vertex_c_y;
  logic [LABEL_BITS-1:0]        triangle_label;
  logic [ReadCoordW-1:0]        read_row;
  logic [ReadCoordW-1:0]        read_col;

  modport source (
    output valid, opcode, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
           vertex_c_x, vertex_c_y, triangle_label, read_row, read_col,
    input  ready
  );
  modport sink (
    input  valid, opcode, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
           vertex_c_x, vertex_c_y, triangle_label, read_row, read_col,
    output ready
  );
endinterface

interface tslf_rsp_if #(
  parameter int unsigned LABEL_BITS = tslf_pkg::DefLabelBits
);
  logic                  valid;
  logic                  ready;
  logic [LABEL_BITS-1:0] pixel_label;
  logic                  was_read;

  modport source (output valid, pixel_label, was_read, input ready);
  modport sink (input valid, pixel_label, was_read, output ready);
endinterface

interface tslf_cfg_if;
  import tslf_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/tslf_ram.sv
module tslf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port, read data registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/triangle_scanline_label_fill_unit.sv
// Triangle scanline label fill unit.
//
// The block holds a label image of MAX_ROWS x MAX_COLS pixels. Requests arrive
// on req_i: a draw rasterises one triangle with a label, a read returns one
// pixel, a clear zeroes the image. Every request gives exactly one response on
// rsp_o. cfg_i writes the rows and columns in use; it is always ready.
//
// One request is worked on at a time, and req_i is ready only while the unit
// is idle. A clear sweeps the whole image RAM, one pixel per cycle. A draw
// first sets the extents of the clipped rows, then steps the points of each
// edge through a read-modify-write of the extent RAM, and then fills
// each row from its extents through the single image RAM port.
//
// After reset the image is cleared by the same sweep before the first request
// is taken. The response sits in an output register: a stalled receiver holds
// it there, and the next request may already be taken, but a finished request
// waits until the register is free.
module triangle_scanline_label_fill_unit #(
  parameter int unsigned MAX_ROWS   = tslf_pkg::DefMaxRows,
  parameter int unsigned MAX_COLS   = tslf_pkg::DefMaxCols,
  parameter int unsigned LABEL_BITS = tslf_pkg::DefLabelBits,
  parameter int unsigned COORD_BITS = tslf_pkg::DefCoordBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tslf_cfg_if.sink   cfg_i,
  tslf_req_if.sink   req_i,
  tslf_rsp_if.source rsp_o
);
  import tslf_pkg::*;

  localparam int unsigned RowW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ColW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned AddrW    = RowW + ColW;
  localparam int unsigned ImgDepth = 1 << AddrW;
  localparam int unsigned RDimW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned CDimW    = $clog2(MAX_COLS + 1);
  // Extents hold vertex columns and also cols+1, so they need the wider of both.
  localparam int unsigned ExtW     = ((COORD_BITS > ColW + 2) ? COORD_BITS : ColW + 2) + 1;
  localparam int unsigned QW       = COORD_BITS + 1;
  localparam int unsigned RemW     = COORD_BITS + 4;
  localparam logic [RDimW-1:0] RowsRst = RDimW'((MAX_ROWS < 256) ? MAX_ROWS : 256);
  localparam logic [CDimW-1:0] ColsRst = CDimW'((MAX_COLS < 256) ? MAX_COLS : 256);

  typedef enum logic [12:0] {
    S_CLEAR     = 13'h0001,
    S_IDLE      = 13'h0002,
    S_READ      = 13'h0004,
    S_READ_DATA = 13'h0008,
    S_SETUP     = 13'h0010,
    S_INIT      = 13'h0020,
    S_EDGE      = 13'h0040,
    S_PT_RD     = 13'h0080,
    S_PT_WR     = 13'h0100,
    S_FILL_RD   = 13'h0200,
    S_FILL_LOAD = 13'h0400,
    S_FILL_COL  = 13'h0800,
    S_DONE      = 13'h1000
  } state_e;

  // Control registers.
  state_e           state_q, state_d;
  logic [RDimW-1:0] rows_q, rows_d;
  logic [CDimW-1:0] cols_q, cols_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic             clr_ack_q, clr_ack_d;
  logic [RowW-1:0]  r_q, r_d;
  logic [1:0]       e_q, e_d;
  logic [COORD_BITS-1:0] cnt_q, cnt_d;
  logic [ColW-1:0]  c_q, c_d;
  logic             rsp_valid_q, rsp_valid_d;

  // Payload registers.
  logic signed [COORD_BITS-1:0] vx_q [3];
  logic signed [COORD_BITS-1:0] vx_d [3];
  logic signed [COORD_BITS-1:0] vy_q [3];
  logic signed [COORD_BITS-1:0] vy_d [3];
  logic [LABEL_BITS-1:0] label_q, label_d;
  logic [RowW-1:0]       rd_row_q, rd_row_d;
  logic [ColW-1:0]       rd_col_q, rd_col_d;
  logic                  rd_ok_q, rd_ok_d;
  logic [RowW-1:0]       r1_q, r1_d, r2_q, r2_d;
  logic [ColW-1:0]       chi_q, chi_d;
  logic signed [QW-1:0]  qx_q, qx_d, qy_q, qy_d;
  logic signed [RemW-1:0] rx_q, rx_d, ry_q, ry_d;
  logic signed [RemW-1:0] dlx_q, dlx_d, dly_q, dly_d, dd_q, dd_d;
  logic [LABEL_BITS-1:0] res_label_q, res_label_d;
  logic                  res_read_q, res_read_d;
  logic [LABEL_BITS-1:0] rsp_label_q, rsp_label_d;
  logic                  rsp_read_q, rsp_read_d;

  // Memories.
  logic                  img_we;
  logic [AddrW-1:0]      img_addr;
  logic [LABEL_BITS-1:0] img_wdata, img_rdata;
  logic                  ext_we;
  logic [RowW-1:0]       ext_addr;
  logic [2*ExtW-1:0]     ext_wdata, ext_rdata;

  // Edge ordering and point arithmetic.
  logic signed [COORD_BITS-1:0] lo_x [3];
  logic signed [COORD_BITS-1:0] lo_y [3];
  logic signed [COORD_BITS-1:0] hi_x [3];
  logic signed [COORD_BITS-1:0] hi_y [3];
  logic signed [ExtW-1:0] hgt [3];
  logic [1:0]             tall;
  logic signed [ExtW-1:0] rows_e, cols_e, r1_e, r2_e;
  logic signed [RemW-1:0] dxs, dys, adx, ady, len_r;
  logic signed [RemW-1:0] rxn, ryn;
  logic signed [QW-1:0]   px, py;
  logic signed [ExtW-1:0] px_e, py_e, emin, emax, nmin, nmax, flo_e, fhi_e;
  logic                   row_in;

  tslf_ram #(.WIDTH(LABEL_BITS), .DEPTH(ImgDepth)) u_img_ram (
    .clk_i  (clk_i),
    .we_i   (img_we),
    .addr_i (img_addr),
    .wdata_i(img_wdata),
    .rdata_o(img_rdata)
  );

  tslf_ram #(.WIDTH(2 * ExtW), .DEPTH(1 << RowW)) u_ext_ram (
    .clk_i  (clk_i),
    .we_i   (ext_we),
    .addr_i (ext_addr),
    .wdata_i(ext_wdata),
    .rdata_o(ext_rdata)
  );

  assign cfg_i.ready       = 1'b1;
  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.pixel_label = rsp_label_q;
  assign rsp_o.was_read    = rsp_read_q;

  assign rows_e = $signed(ExtW'(rows_q));
  assign cols_e = $signed(ExtW'(cols_q));

  // Edges AB, BC and CA, each with its lower row first; on equal rows the
  // second-named vertex comes first.
  always_comb begin
    int kn;
    kn = 0;
    for (int k = 0; k < 3; k++) begin
      kn = (k == 2) ? 0 : k + 1;
      if (vy_q[k] < vy_q[kn]) begin
        lo_x[k] = vx_q[k];  lo_y[k] = vy_q[k];
        hi_x[k] = vx_q[kn]; hi_y[k] = vy_q[kn];
      end else begin
        lo_x[k] = vx_q[kn]; lo_y[k] = vy_q[kn];
        hi_x[k] = vx_q[k];  hi_y[k] = vy_q[k];
      end
      hgt[k] = ExtW'(hi_y[k]) - ExtW'(lo_y[k]);
    end
  end

  // The tallest edge spans the whole triangle and gives the row range.
  always_comb begin
    priority if (hgt[0] >= hgt[1] && hgt[0] >= hgt[2]) begin
      tall = 2'd0;
    end else if (hgt[1] >= hgt[0] && hgt[1] >= hgt[2]) begin
      tall = 2'd1;
    end else begin
      tall = 2'd2;
    end
    r1_e = ExtW'(lo_y[tall]);
    r2_e = ExtW'(hi_y[tall]);
    if (r1_e < 0) begin
      r1_e = '0;
    end
    if (r2_e >= rows_e) begin
      r2_e = rows_e - ExtW'(1);
    end
  end

  // Length of the current edge.
  always_comb begin
    dxs   = RemW'(hi_x[e_q]) - RemW'(lo_x[e_q]);
    dys   = RemW'(hi_y[e_q]) - RemW'(lo_y[e_q]);
    adx   = (dxs < 0) ? -dxs : dxs;
    ady   = (dys < 0) ? -dys : dys;
    len_r = (adx > ady) ? adx : ady;
  end

  // The point is the floor quotient q with remainder r of the rounded
  // interpolation over 2L; truncation toward zero adds one when the quotient is
  // negative and the remainder is not zero. Each step adds at most 2L to r, so
  // one correction keeps it in range.
  always_comb begin
    px   = qx_q + (((qx_q < 0) && (rx_q != 0)) ? QW'(1) : QW'(0));
    py   = qy_q + (((qy_q < 0) && (ry_q != 0)) ? QW'(1) : QW'(0));
    px_e = ExtW'(px);
    py_e = ExtW'(py);
    row_in = (py_e >= 0) && (py_e < rows_e);
    rxn  = rx_q + dlx_q;
    ryn  = ry_q + dly_q;
    emin = $signed(ext_rdata[2*ExtW-1:ExtW]);
    emax = $signed(ext_rdata[ExtW-1:0]);
    nmin = (px_e < emin) ? px_e : emin;
    nmax = (px_e > emax) ? px_e : emax;
    flo_e = (emin < 0) ? '0 : emin;
    fhi_e = (emax >= cols_e) ? cols_e - ExtW'(1) : emax;
  end

  // Memory ports.
  always_comb begin
    img_we    = 1'b0;
    img_wdata = label_q;
    img_addr  = {r_q, c_q};
    ext_we    = 1'b0;
    ext_addr  = r_q;
    ext_wdata = {nmin, nmax};
    unique case (state_q)
      S_CLEAR: begin
        img_we    = 1'b1;
        img_wdata = '0;
        img_addr  = clr_q;
      end
      S_READ: begin
        img_addr = {rd_row_q, rd_col_q};
      end
      S_FILL_COL: begin
        img_we = 1'b1;
      end
      S_INIT: begin
        ext_we    = 1'b1;
        ext_wdata = {cols_e + ExtW'(1), {ExtW{1'b1}}};
      end
      S_PT_RD: begin
        ext_addr = RowW'(py);
      end
      S_PT_WR: begin
        ext_addr = RowW'(py);
        ext_we   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    logic adv;
    adv = 1'b0;

    state_d     = state_q;
    rows_d      = rows_q;
    cols_d      = cols_q;
    clr_d       = clr_q;
    clr_ack_d   = clr_ack_q;
    r_d         = r_q;
    e_d         = e_q;
    cnt_d       = cnt_q;
    c_d         = c_q;
    vx_d        = vx_q;
    vy_d        = vy_q;
    label_d     = label_q;
    rd_row_d    = rd_row_q;
    rd_col_d    = rd_col_q;
    rd_ok_d     = rd_ok_q;
    r1_d        = r1_q;
    r2_d        = r2_q;
    chi_d       = chi_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    rx_d        = rx_q;
    ry_d        = ry_q;
    dlx_d       = dlx_q;
    dly_d       = dly_q;
    dd_d        = dd_q;
    res_label_d = res_label_q;
    res_read_d  = res_read_q;
    rsp_label_d = rsp_label_q;
    rsp_read_d  = rsp_read_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;

    // A value of zero counts as one, and a value above the maximum as the maximum.
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegImageRows: begin
          if (cfg_i.data == '0) begin
            rows_d = RDimW'(1);
          end else if (32'(cfg_i.data) > MAX_ROWS) begin
            rows_d = RDimW'(MAX_ROWS);
          end else begin
            rows_d = RDimW'(cfg_i.data);
          end
        end
        RegImageCols: begin
          if (cfg_i.data == '0) begin
            cols_d = CDimW'(1);
          end else if (32'(cfg_i.data) > MAX_COLS) begin
            cols_d = CDimW'(MAX_COLS);
          end else begin
            cols_d = CDimW'(cfg_i.data);
          end
        end
        default: begin
        end
      endcase
    end

    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + AddrW'(1);
        if (&clr_q) begin
          res_label_d = '0;
          res_read_d  = 1'b0;
          state_d     = clr_ack_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          res_label_d = '0;
          res_read_d  = 1'b0;
          unique case (req_i.opcode)
            OpDraw: begin
              vx_d[0] = req_i.vertex_a_x; vy_d[0] = req_i.vertex_a_y;
              vx_d[1] = req_i.vertex_b_x; vy_d[1] = req_i.vertex_b_y;
              vx_d[2] = req_i.vertex_c_x; vy_d[2] = req_i.vertex_c_y;
              label_d = req_i.triangle_label;
              state_d = S_SETUP;
            end
            OpRead: begin
              rd_row_d = RowW'(req_i.read_row);
              rd_col_d = ColW'(req_i.read_col);
              rd_ok_d  = (32'(req_i.read_row) < 32'(rows_q)) &&
                         (32'(req_i.read_col) < 32'(cols_q));
              state_d  = S_READ;
            end
            OpClear: begin
              clr_d     = '0;
              clr_ack_d = 1'b1;
              state_d   = S_CLEAR;
            end
            OpUnused: begin
              state_d = S_DONE;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        state_d = S_READ_DATA;
      end
      S_READ_DATA: begin
        res_label_d = rd_ok_q ? img_rdata : '0;
        res_read_d  = 1'b1;
        state_d     = S_DONE;
      end
      S_SETUP: begin
        if (r1_e > r2_e) begin
          // Triangle wholly above or below the image.
          state_d = S_DONE;
        end else begin
          r1_d    = RowW'(r1_e);
          r_d     = RowW'(r1_e);
          r2_d    = RowW'(r2_e);
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        if (r_q == r2_q) begin
          e_d     = 2'd0;
          state_d = S_EDGE;
        end else begin
          r_d = r_q + RowW'(1);
        end
      end
      S_EDGE: begin
        qx_d    = QW'(hi_x[e_q]);
        qy_d    = QW'(hi_y[e_q]);
        rx_d    = len_r;
        ry_d    = len_r;
        dlx_d   = (RemW'(lo_x[e_q]) - RemW'(hi_x[e_q])) <<< 1;
        dly_d   = (RemW'(lo_y[e_q]) - RemW'(hi_y[e_q])) <<< 1;
        dd_d    = len_r <<< 1;
        cnt_d   = COORD_BITS'(len_r);
        state_d = S_PT_RD;
      end
      S_PT_RD: begin
        if (row_in) begin
          state_d = S_PT_WR;
        end else begin
          adv = 1'b1;
        end
      end
      S_PT_WR: begin
        adv = 1'b1;
      end
      S_FILL_RD: begin
        state_d = S_FILL_LOAD;
      end
      S_FILL_LOAD: begin
        if (flo_e <= fhi_e) begin
          c_d     = ColW'(flo_e);
          chi_d   = ColW'(fhi_e);
          state_d = S_FILL_COL;
        end else if (r_q == r2_q) begin
          state_d = S_DONE;
        end else begin
          r_d     = r_q + RowW'(1);
          state_d = S_FILL_RD;
        end
      end
      S_FILL_COL: begin
        if (c_q != chi_q) begin
          c_d = c_q + ColW'(1);
        end else if (r_q == r2_q) begin
          state_d = S_DONE;
        end else begin
          r_d     = r_q + RowW'(1);
          state_d = S_FILL_RD;
        end
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_label_d = res_label_q;
          rsp_read_d  = res_read_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Step to the next point, the next edge or the fill.
    if (adv) begin
      if (cnt_q == '0) begin
        if (e_q == 2'd2) begin
          r_d     = r1_q;
          state_d = S_FILL_RD;
        end else begin
          e_d     = e_q + 2'd1;
          state_d = S_EDGE;
        end
      end else begin
        cnt_d   = cnt_q - COORD_BITS'(1);
        state_d = S_PT_RD;
        if (rxn >= dd_q) begin
          rx_d = rxn - dd_q;
          qx_d = qx_q + QW'(1);
        end else if (rxn < 0) begin
          rx_d = rxn + dd_q;
          qx_d = qx_q - QW'(1);
        end else begin
          rx_d = rxn;
        end
        if (ryn >= dd_q) begin
          ry_d = ryn - dd_q;
          qy_d = qy_q + QW'(1);
        end else if (ryn < 0) begin
          ry_d = ryn + dd_q;
          qy_d = qy_q - QW'(1);
        end else begin
          ry_d = ryn;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rows_q      <= RowsRst;
      cols_q      <= ColsRst;
      clr_q       <= '0;
      clr_ack_q   <= 1'b0;
      r_q         <= '0;
      e_q         <= '0;
      cnt_q       <= '0;
      c_q         <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rows_q      <= rows_d;
      cols_q      <= cols_d;
      clr_q       <= clr_d;
      clr_ack_q   <= clr_ack_d;
      r_q         <= r_d;
      e_q         <= e_d;
      cnt_q       <= cnt_d;
      c_q         <= c_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vx_q        <= vx_d;
    vy_q        <= vy_d;
    label_q     <= label_d;
    rd_row_q    <= rd_row_d;
    rd_col_q    <= rd_col_d;
    rd_ok_q     <= rd_ok_d;
    r1_q        <= r1_d;
    r2_q        <= r2_d;
    chi_q       <= chi_d;
    qx_q        <= qx_d;
    qy_q        <= qy_d;
    rx_q        <= rx_d;
    ry_q        <= ry_d;
    dlx_q       <= dlx_d;
    dly_q       <= dly_d;
    dd_q        <= dd_d;
    res_label_q <= res_label_d;
    res_read_q  <= res_read_d;
    rsp_label_q <= rsp_label_d;
    rsp_read_q  <= rsp_read_d;
  end

endmodule

FILE: hw/rtl/tslf_checker.sv
module tslf_checker #(
  parameter int unsigned LABEL_BITS = tslf_pkg::DefLabelBits
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  req_valid_i,
  input logic                  req_ready_i,
  input logic                  rsp_valid_i,
  input logic                  rsp_ready_i,
  input logic                  rsp_was_read_i,
  input logic [LABEL_BITS-1:0] rsp_pixel_label_i
);

  // Requests taken whose responses have not yet been taken.
  logic [1:0] osd_q, osd_d;
  logic       req_acc, rsp_acc;

  assign req_acc = req_valid_i && req_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;

  always_comb begin
    osd_d = osd_q;
    if (req_acc && !rsp_acc) begin
      osd_d = osd_q + 2'd1;
    end else if (!req_acc && rsp_acc) begin
      osd_d = osd_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      osd_q <= '0;
    end else begin
      osd_q <= osd_d;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_rsp_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> osd_q != 2'd0)
    else $error("response without a request");

  a_osd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    osd_q != 2'd3)
    else $error("more than two requests outstanding");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    osd_q == 2'd2 |-> !req_ready_i)
    else $error("request taken while one is in work and one waits");

  a_ack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_was_read_i |-> rsp_pixel_label_i == '0)
    else $error("acknowledge carries a label");

endmodule

bind triangle_scanline_label_fill_unit tslf_checker #(
  .LABEL_BITS(LABEL_BITS)
) u_tslf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_was_read_i   (rsp_o.was_read),
  .rsp_pixel_label_i(rsp_o.pixel_label)
);

FILE: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tslf_pkg::*;

  // One draw, read, clear or unused request as the bench sees it.
  typedef struct {
    logic [OpcodeW-1:0] op;
    logic signed [10:0] ax, ay, bx, by, cx, cy;
    logic [15:0]        label;
    logic [7:0]         row, col;
  } tri_req_t;

  // One response that the unit owes us.
  typedef struct {
    logic [15:0] label;
    logic        was_read;
  } pixel_rsp_t;

  logic clk;
  logic rst_n;

  tslf_cfg_if cfg_if ();
  tslf_req_if req_if ();
  tslf_rsp_if rsp_if ();

  triangle_scanline_label_fill_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Our own copy of the label image, the per-row extents and the sizes in use.
  logic [15:0] shadow_image [256][256];
  longint      span_min [256];
  longint      span_max [256];
  int          rows_in_use;
  int          cols_in_use;

  pixel_rsp_t  pending_rsps [$];
  int          error_count;
  bit          sender_eager;    // no gaps between requests while set
  bit          receiver_eager;  // no response stalls while set
  int          rsp_hold;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The run may not hang: a watchdog ends it and reports a failure.
  initial begin
    #40ms;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Prediction of the unit's behaviour.
  // ---------------------------------------------------------------------------

  function automatic int clamp_size(input logic [8:0] value);
    if (value == 0) return 1;
    if (value > 256) return 256;
    return int'(value);
  endfunction

  function automatic void clear_image();
    for (int r = 0; r < 256; r++) begin
      for (int c = 0; c < 256; c++) begin
        shadow_image[r][c] = '0;
      end
    end
  endfunction

  // A point widens its row's extents only when the row lies inside the image.
  function automatic void widen_span(input longint row, input longint col);
    if (row >= 0 && row < rows_in_use) begin
      if (col < span_min[row]) span_min[row] = col;
      if (col > span_max[row]) span_max[row] = col;
    end
  endfunction

  // Steps one edge over max(|dx|,|dy|)+1 rounded points. SystemVerilog integer
  // division truncates toward zero, which is exactly what the rounding needs.
  function automatic void step_edge(input longint x1, input longint y1,
                                    input longint x2, input longint y2);
    longint dx, dy, len, x, y;
    dx = (x2 > x1) ? x2 - x1 : x1 - x2;
    dy = (y2 > y1) ? y2 - y1 : y1 - y2;
    len = (dx > dy) ? dx : dy;
    if (len == 0) begin
      widen_span(y1, x1);
      return;
    end
    for (longint i = 0; i <= len; i++) begin
      x = (2 * (x1 * i + x2 * (len - i)) + len) / (2 * len);
      y = (2 * (y1 * i + y2 * (len - i)) + len) / (2 * len);
      widen_span(y, x);
    end
  endfunction

  function automatic void rasterise(input tri_req_t r);
    longint vx [3];
    longint vy [3];
    longint lox [3], loy [3], hix [3], hiy [3];
    longint h [3];
    longint first_row, last_row, lo, hi;
    int tallest, p, q;
    vx[0] = r.ax; vy[0] = r.ay;
    vx[1] = r.bx; vy[1] = r.by;
    vx[2] = r.cx; vy[2] = r.cy;
    // Edges AB, BC, CA; on equal rows the second-named vertex comes first.
    for (int e = 0; e < 3; e++) begin
      p = e;
      q = (e + 1) % 3;
      if (vy[p] < vy[q]) begin
        lox[e] = vx[p]; loy[e] = vy[p]; hix[e] = vx[q]; hiy[e] = vy[q];
      end else begin
        lox[e] = vx[q]; loy[e] = vy[q]; hix[e] = vx[p]; hiy[e] = vy[p];
      end
      h[e] = hiy[e] - loy[e];
    end
    if (h[0] >= h[1] && h[0] >= h[2]) tallest = 0;
    else if (h[1] >= h[0] && h[1] >= h[2]) tallest = 1;
    else tallest = 2;

    first_row = (loy[tallest] < 0) ? 0 : loy[tallest];
    last_row  = (hiy[tallest] >= rows_in_use) ? rows_in_use - 1 : hiy[tallest];
    for (longint row = first_row; row <= last_row; row++) begin
      span_min[row] = cols_in_use + 1;
      span_max[row] = -1;
    end
    for (int e = 0; e < 3; e++) step_edge(lox[e], loy[e], hix[e], hiy[e]);
    for (longint row = first_row; row <= last_row; row++) begin
      lo = (span_min[row] < 0) ? 0 : span_min[row];
      hi = (span_max[row] >= cols_in_use) ? cols_in_use - 1 : span_max[row];
      for (longint col = lo; col <= hi; col++) shadow_image[row][col] = r.label;
    end
  endfunction

  function automatic pixel_rsp_t predict_response(input tri_req_t r);
    pixel_rsp_t rsp;
    rsp.label    = '0;
    rsp.was_read = 1'b0;
    case (r.op)
      OpDraw: begin
        rasterise(r);
      end
      OpRead: begin
        rsp.was_read = 1'b1;
        if (r.row < rows_in_use && r.col < cols_in_use) rsp.label = shadow_image[r.row][r.col];
      end
      OpClear: begin
        clear_image();
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving requests and configuration.
  // ---------------------------------------------------------------------------

  // Valid is only lowered when a gap follows, so that back-to-back requests
  // never see a lower and a raise of valid in the same time step.
  task automatic send_request(input tri_req_t r);
    int gap;
    gap = sender_eager ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid          <= 1'b1;
    req_if.opcode         <= r.op;
    req_if.vertex_a_x     <= r.ax;
    req_if.vertex_a_y     <= r.ay;
    req_if.vertex_b_x     <= r.bx;
    req_if.vertex_b_y     <= r.by;
    req_if.vertex_c_x     <= r.cx;
    req_if.vertex_c_y     <= r.cy;
    req_if.triangle_label <= r.label;
    req_if.read_row       <= r.row;
    req_if.read_col       <= r.col;
    do @(posedge clk); while (!req_if.ready);
    pending_rsps.push_back(predict_response(r));
  endtask

  // Drops valid and waits until every owed response has come back.
  task automatic drain_responses();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] index, input logic [8:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (index == RegImageRows) rows_in_use = clamp_size(value);
    else cols_in_use = clamp_size(value);
    @(posedge clk);
  endtask

  task automatic set_image_size(input logic [8:0] rows, input logic [8:0] cols);
    drain_responses();
    write_register(RegImageRows, rows);
    write_register(RegImageCols, cols);
  endtask

  function automatic tri_req_t make_triangle(input int ax, input int ay, input int bx,
                                             input int by, input int cx, input int cy,
                                             input logic [15:0] label);
    tri_req_t r;
    r.op = OpDraw;
    r.ax = 11'(ax); r.ay = 11'(ay); r.bx = 11'(bx);
    r.by = 11'(by); r.cx = 11'(cx); r.cy = 11'(cy);
    r.label = label;
    r.row = 8'($urandom());
    r.col = 8'($urandom());
    return r;
  endfunction

  function automatic tri_req_t make_read(input int row, input int col);
    tri_req_t r;
    r = make_triangle($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom(), 16'($urandom()));
    r.op  = OpRead;
    r.row = 8'(row);
    r.col = 8'(col);
    return r;
  endfunction

  function automatic tri_req_t make_other(input logic [OpcodeW-1:0] op);
    tri_req_t r;
    r = make_read($urandom(), $urandom());
    r.op = op;
    return r;
  endfunction

  // A small triangle near the image, possibly partly off it.
  function automatic tri_req_t small_triangle();
    int bx, by;
    bx = $urandom_range(0, 280) - 12;
    by = $urandom_range(0, 280) - 12;
    return make_triangle(bx, by,
                         bx + $urandom_range(0, 40) - 20, by + $urandom_range(0, 40) - 20,
                         bx + $urandom_range(0, 40) - 20, by + $urandom_range(0, 40) - 20,
                         16'($urandom()));
  endfunction

  // ---------------------------------------------------------------------------
  // Response side: random stalls, and every response compared with the oldest
  // expectation.
  // ---------------------------------------------------------------------------

  always @(posedge clk or negedge rst_n) begin
    pixel_rsp_t want;
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
      rsp_hold     = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_rsps.size() == 0) begin
          report_mismatch("responses outstanding", 0, 1);
        end else begin
          want = pending_rsps.pop_front();
          if (rsp_if.pixel_label !== want.label)
            report_mismatch("pixel_label", rsp_if.pixel_label, want.label);
          if (rsp_if.was_read !== want.was_read)
            report_mismatch("was_read", rsp_if.was_read, want.was_read);
        end
        rsp_hold     = receiver_eager ? 0 : $urandom_range(0, 19);
        rsp_if.ready <= (rsp_hold == 0);
      end else if (rsp_hold > 0) begin
        rsp_hold     = rsp_hold - 1;
        rsp_if.ready <= (rsp_hold == 0);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Extremes of the fields and every operation at the reset size.
  task automatic test_operations();
    send_request(make_read(0, 0));
    send_request(make_read(255, 255));
    send_request(make_triangle(10, 10, 30, 12, 15, 40, 16'hffff));
    send_request(make_read(20, 18));
    send_request(make_read(10, 10));
    // A degenerate triangle that collapses onto one point.
    send_request(make_triangle(100, 5, 100, 5, 100, 5, 16'h0001));
    send_request(make_read(5, 100));
    // A flat triangle, all three vertices on one row.
    send_request(make_triangle(50, 60, 90, 60, 70, 60, 16'h1234));
    send_request(make_read(60, 70));
    // Entirely above the image: the clipped row range is empty.
    send_request(make_triangle(-1024, -1024, 1023, -900, 0, -1, 16'hbeef));
    send_request(make_read(0, 0));
    // Straddles the image on every side and fills each pixel whose column does not exceed its row.
    send_request(make_triangle(-1024, -1024, 1023, 1023, -1024, 1023, 16'h5a5a));
    send_request(make_read(255, 0));
    send_request(make_read(0, 255));
    send_request(make_other(OpUnused));
    send_request(make_other(OpClear));
    send_request(make_read(128, 128));
    send_request(make_triangle(255, 0, 0, 255, 255, 255, 16'h8000));
    send_request(make_read(255, 255));
    drain_responses();
  endtask

  // Smallest and out-of-range sizes, and reads past the bounds in use.
  task automatic test_image_size();
    set_image_size(9'd1, 9'd1);
    send_request(make_triangle(-5, -5, 5, 0, 0, 5, 16'h00aa));
    send_request(make_read(0, 0));
    send_request(make_read(0, 1));
    send_request(make_read(1, 0));
    set_image_size(9'd0, 9'd511);
    send_request(make_read(0, 200));
    send_request(make_triangle(-3, -2, 300, 0, 40, 1, 16'h0f0f));
    send_request(make_read(0, 255));
    set_image_size(9'd256, 9'd256);
    send_request(make_read(0, 255));
    send_request(make_read(1, 100));
  endtask

  // Random traffic in chunks, each at a fresh image size.
  task automatic test_random_traffic();
    tri_req_t r;
    int pick;
    for (int chunk = 0; chunk < 4; chunk++) begin
      case (chunk)
        0: set_image_size(9'd256, 9'd256);
        1: set_image_size(9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)));
        2: set_image_size(9'($urandom_range(1, 16)), 9'd256);
        default: set_image_size(9'($urandom()), 9'($urandom()));
      endcase
      for (int n = 0; n < 75; n++) begin
        if (n % 25 == 0) begin
          sender_eager   = ($urandom_range(0, 3) == 0);
          receiver_eager = ($urandom_range(0, 3) == 0);
        end
        pick = $urandom_range(0, 99);
        if (n == 40 && chunk[0]) r = make_other(OpClear);
        else if (pick < 2) r = make_other(OpUnused);
        else if (pick < 4) begin
          // Rare full-range vertices so that every coordinate bit toggles.
          r = make_triangle($urandom(), $urandom(), $urandom(), $urandom(),
                            $urandom(), $urandom(), 16'($urandom()));
        end else if (pick < 50) r = small_triangle();
        else r = make_read($urandom(), $urandom());
        send_request(r);
      end
    end
    sender_eager   = 1'b0;
    receiver_eager = 1'b0;
    drain_responses();
  endtask

  initial begin
    error_count    = 0;
    sender_eager   = 1'b0;
    receiver_eager = 1'b0;
    rows_in_use    = 256;
    cols_in_use    = 256;
    clear_image();
    for (int r = 0; r < 256; r++) begin
      span_min[r] = 0;
      span_max[r] = 0;
    end
    rst_n                 = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = RegImageRows;
    cfg_if.data           = '0;
    req_if.valid          = 1'b0;
    req_if.opcode         = OpDraw;
    req_if.vertex_a_x     = '0;
    req_if.vertex_a_y     = '0;
    req_if.vertex_b_x     = '0;
    req_if.vertex_b_y     = '0;
    req_if.vertex_c_x     = '0;
    req_if.vertex_c_y     = '0;
    req_if.triangle_label = '0;
    req_if.read_row       = '0;
    req_if.read_col       = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_operations();
    test_image_size();
    test_random_traffic();

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: triangle_scanline_label_fill_unit.f
hw/rtl/tslf_pkg.sv
hw/rtl/tslf_if.sv
hw/rtl/tslf_ram.sv
hw/rtl/triangle_scanline_label_fill_unit.sv
hw/rtl/tslf_checker.sv
bench/tb_top.sv
